[sv/fdss_pkg.sv]
`default_nettype none

package fdss_pkg;

    localparam int VALUE_W   = 14;
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = 4;
    localparam int BCD_W     = DIGIT_W * DIGITS;
    localparam int PATTERN_W = 8;
    localparam int FRAME_W   = PATTERN_W * DIGITS;
    localparam int BIT_CNT_W = $clog2(FRAME_W);

    localparam logic [VALUE_W-1:0]   DISPLAY_MAX = VALUE_W'(9999);
    localparam logic [PATTERN_W-1:0] DOT_MASK    = 8'b0000_0001;

    // One frame of four segment patterns, thousands pattern in the top byte.
    typedef logic [FRAME_W-1:0] frame_t;

    // Write side of the frame queue.
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } q_wr_t;

    // Read side of the frame queue.
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } q_rd_t;

    // Segment pattern, bit 7 down to bit 0 = f,g,e,d,c,b,a,dot.
    function automatic logic [PATTERN_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [PATTERN_W-1:0] pat;
        begin
            case (digit)
                4'd0:    pat = 8'b1011_1110;
                4'd1:    pat = 8'b0000_1100;
                4'd2:    pat = 8'b0111_0110;
                4'd3:    pat = 8'b0101_1110;
                4'd4:    pat = 8'b1100_1100;
                4'd5:    pat = 8'b1101_1010;
                4'd6:    pat = 8'b1111_1010;
                4'd7:    pat = 8'b0000_1110;
                4'd8:    pat = 8'b1111_1110;
                4'd9:    pat = 8'b1101_1110;
                default: pat = 8'b0000_0000;
            endcase
            return pat;
        end
    endfunction

endpackage

`default_nettype wire

[sv/fdss_front.sv]
`default_nettype none

// Takes one value, clamps it and splits it into four decimal digits by
// reciprocal multiplication, then builds the 32-bit segment frame.
module fdss_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fdss_pkg::VALUE_W-1:0]  in_value,
    output fdss_pkg::q_wr_t                    q_wr,
    input  wire logic                          q_full
);

    // The quotients by 1000, 100 and 10 come from a multiplication by a scaled
    // reciprocal, keeping the bits above the scale. They are exact for every
    // value up to 9999.
    localparam int PROD_W  = 2 * fdss_pkg::VALUE_W;
    localparam int Q100_W  = 7;
    localparam int Q10_W   = 10;
    localparam int SH_1000 = 23;
    localparam int SH_100  = 19;
    localparam int SH_10   = 16;
    localparam logic [PROD_W-1:0] RECIP_1000 = PROD_W'(8389);
    localparam logic [PROD_W-1:0] RECIP_100  = PROD_W'(5243);
    localparam logic [PROD_W-1:0] RECIP_10   = PROD_W'(6554);

    typedef enum logic [1:0] {
        IDLE,
        MUL,
        HOLD
    } state_t;

    state_t                            state_reg;
    logic [fdss_pkg::VALUE_W-1:0]      val_reg;
    logic [fdss_pkg::DIGIT_W-1:0]      q1000_reg;
    logic [Q100_W-1:0]                 q100_reg;
    logic [Q10_W-1:0]                  q10_reg;
    logic [PROD_W-1:0]                 prod_1000;
    logic [PROD_W-1:0]                 prod_100;
    logic [PROD_W-1:0]                 prod_10;
    logic [Q100_W-1:0]                 q1000_x10;
    logic [Q10_W-1:0]                  q100_x10;
    logic [fdss_pkg::VALUE_W-1:0]      q10_x10;
    logic [Q100_W-1:0]                 hundreds_full;
    logic [Q10_W-1:0]                  tens_full;
    logic [fdss_pkg::VALUE_W-1:0]      units_full;
    logic [fdss_pkg::VALUE_W-1:0]      clamped;
    logic                              accept;
    logic                              push;
    logic [fdss_pkg::DIGIT_W-1:0]      dig [fdss_pkg::DIGITS];
    logic [fdss_pkg::PATTERN_W-1:0]    pat [fdss_pkg::DIGITS];

    assign clamped = (in_value > fdss_pkg::DISPLAY_MAX) ? fdss_pkg::DISPLAY_MAX : in_value;

    assign prod_1000 = {{fdss_pkg::VALUE_W{1'b0}}, val_reg} * RECIP_1000;
    assign prod_100  = {{fdss_pkg::VALUE_W{1'b0}}, val_reg} * RECIP_100;
    assign prod_10   = {{fdss_pkg::VALUE_W{1'b0}}, val_reg} * RECIP_10;

    // Each digit below the thousands is one quotient less ten times the next coarser quotient.
    assign q1000_x10     = {q1000_reg, 3'b000} + {2'b00, q1000_reg, 1'b0};
    assign q100_x10      = {q100_reg, 3'b000} + {2'b00, q100_reg, 1'b0};
    assign q10_x10       = {1'b0, q10_reg, 3'b000} + {3'b000, q10_reg, 1'b0};
    assign hundreds_full = q100_reg - q1000_x10;
    assign tens_full     = q10_reg - q100_x10;
    assign units_full    = val_reg - q10_x10;

    // Digit 0 is the thousands digit.
    always_comb
    begin
        dig[0] = q1000_reg;
        dig[1] = hundreds_full[fdss_pkg::DIGIT_W-1:0];
        dig[2] = tens_full[fdss_pkg::DIGIT_W-1:0];
        dig[3] = units_full[fdss_pkg::DIGIT_W-1:0];
        for (int k = 0; k < fdss_pkg::DIGITS; k++)
        begin
            pat[k] = fdss_pkg::seg_pattern(dig[k]);
        end
        // Tens dot follows an even hundreds digit, units dot an odd thousands digit.
        if (!dig[1][0])
        begin
            pat[2] = pat[2] | fdss_pkg::DOT_MASK;
        end
        if (dig[0][0])
        begin
            pat[3] = pat[3] | fdss_pkg::DOT_MASK;
        end
    end

    assign q_wr.valid = (state_reg == HOLD);
    assign q_wr.frame = {pat[0], pat[1], pat[2], pat[3]};
    assign push       = (state_reg == HOLD) && !q_full;
    assign in_ready   = (state_reg == IDLE) || push;
    assign accept     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            case (state_reg)
                IDLE, HOLD:
                begin
                    if (accept)
                    begin
                        state_reg <= MUL;
                    end
                    else if (push)
                    begin
                        state_reg <= IDLE;
                    end
                end
                MUL:
                begin
                    state_reg <= HOLD;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg <= clamped;
        end
        if (state_reg == MUL)
        begin
            q1000_reg <= prod_1000[SH_1000 +: fdss_pkg::DIGIT_W];
            q100_reg  <= prod_100[SH_100 +: Q100_W];
            q10_reg   <= prod_10[SH_10 +: Q10_W];
        end
    end

endmodule

`default_nettype wire

[sv/fdss_queue.sv]
`default_nettype none

// Small frame queue between the converter and the serialiser.
module fdss_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fdss_pkg::q_wr_t q_wr,
    output logic               q_full,
    output fdss_pkg::q_rd_t    q_rd,
    input  wire logic          q_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    fdss_pkg::frame_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               wr_en;
    logic               rd_en;

    assign q_full     = (count_reg == FULL_CNT);
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.frame = mem_reg[rd_ptr_reg];
    assign wr_en      = q_wr.valid && !q_full;
    assign rd_en      = q_pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.frame;
        end
    end

endmodule

`default_nettype wire

[sv/fdss_back.sv]
`default_nettype none

// Serialiser: shifts each frame out MSB first, one bit per transaction.
module fdss_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fdss_pkg::q_rd_t q_rd,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               out_bit,
    output logic               out_last
);

    localparam logic [fdss_pkg::BIT_CNT_W-1:0] LAST_BIT =
        fdss_pkg::BIT_CNT_W'(fdss_pkg::FRAME_W - 1);

    fdss_pkg::frame_t                  shift_reg;
    fdss_pkg::frame_t                  shift_next;
    logic [fdss_pkg::BIT_CNT_W-1:0]    cnt_reg;
    logic [fdss_pkg::BIT_CNT_W-1:0]    cnt_next;
    logic                              valid_reg;
    logic                              valid_next;
    logic                              load;

    assign out_valid = valid_reg;
    assign out_bit   = shift_reg[fdss_pkg::FRAME_W-1];
    assign out_last  = (cnt_reg == LAST_BIT);
    assign load      = !valid_reg || (out_ready && out_last);
    assign q_pop     = load && q_rd.valid;

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = q_rd.valid;
            shift_next = q_rd.frame;
            cnt_next   = '0;
        end
        else if (out_ready)
        begin
            shift_next = {shift_reg[fdss_pkg::FRAME_W-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

`default_nettype wire

[sv/four_digit_seven_segment_shift_out.sv]
// Path: an accepted value passes the MUL and HOLD states, HOLD writes its frame to the
// queue, and an idle serialiser then loads the frame and offers the first serial bit.
// Throughput: one serial bit per cycle while m_tready is high, and no gap between queued
// frames; the converter takes a new value in the cycle it pushes a frame and runs ahead.
// Reset: rst_n is asynchronous and active low; it empties the queue and all control state.
`default_nettype none

module four_digit_seven_segment_shift_out
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [13:0] value, [15:14] zero fill

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] seg_bit, [7:1] zero fill
    output logic             m_tlast
);

    // The front end converts a value into a frame of four segment patterns and
    // places it in the queue; the back end shifts frames out one bit per
    // transaction. The queue lets the converter run ahead while the serialiser
    // is busy, and lets the serialiser keep going when no value arrives.

    fdss_pkg::q_wr_t    q_wr;
    fdss_pkg::q_rd_t    q_rd;
    logic               q_full;
    logic               q_pop;
    logic               seg_bit;

    fdss_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_value (s_tdata[fdss_pkg::VALUE_W-1:0]),
        .q_wr     (q_wr),
        .q_full   (q_full)
    );

    fdss_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_rd   (q_rd),
        .q_pop  (q_pop)
    );

    fdss_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_bit   (seg_bit),
        .out_last  (m_tlast)
    );

    // The serial bit sits in the lowest bit of the byte.
    assign m_tdata = {7'b000_0000, seg_bit};

`ifndef SYNTHESIS
    // A value that has just been taken keeps the converter busy in the next cycle.
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("converter accepted two values in consecutive cycles");

    // A frame is never broken off before its last bit.
    a_frame_whole: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("serial output stopped in the middle of a frame");

    // A queued frame follows the previous one with no gap.
    a_frames_abut: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast && q_rd.valid |=> m_tvalid)
        else $error("gap between frames although a frame was waiting");

    // The serialiser only takes a frame when the queue holds one.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_rd.valid && !(q_full && q_wr.valid && !q_rd.valid))
        else $error("frame taken from an empty queue");
`endif

endmodule

`default_nettype wire
